### rtl/psfc_pkg.sv
// Shared types, register indexes and constants for the pendulum balance controller.
package psfc_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_TARGET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd7;

  localparam logic [8:0]         RST_SMOOTH      = 9'd77;
  localparam logic signed [23:0] RST_ANGLE_GAIN  = 24'sd15000;
  localparam logic signed [23:0] RST_TILT_GAIN   = 24'sd2400;
  localparam logic signed [23:0] RST_POS_GAIN    = 24'sd0;
  localparam logic signed [23:0] RST_SPEED_GAIN  = 24'sd0;
  localparam logic signed [23:0] RST_TURN_GAIN   = 24'sd4800;
  localparam logic signed [15:0] RST_TURN_TARGET = 16'sd0;
  localparam logic [22:0]        RST_DRIVE_LIMIT = 23'd120000;

  localparam logic [8:0] SMOOTH_MAX = 9'd256;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_TOGGLE = 1'b1;

  localparam int TERM_W = 3;
  localparam logic [TERM_W-1:0] TERM_ROLL  = 3'd0;
  localparam logic [TERM_W-1:0] TERM_TILT  = 3'd1;
  localparam logic [TERM_W-1:0] TERM_POS   = 3'd2;
  localparam logic [TERM_W-1:0] TERM_SPEED = 3'd3;
  localparam logic [TERM_W-1:0] TERM_TURN  = 3'd4;

  localparam int OPB_W  = 34;
  localparam int PROD_W = 58;
  localparam int ACC_W  = 60;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] roll_angle;
    logic signed [15:0] tilt_rate;
    logic signed [15:0] yaw_rate;
    logic signed [31:0] wheel_position;
    logic signed [31:0] wheel_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] right_drive;
    logic signed [23:0] left_drive;
    logic               running;
  } out_word_t;

  typedef struct packed {
    logic              load_in;
    logic              toggle;
    logic              filt;
    logic              mul_en;
    logic [TERM_W-1:0] term;
    logic              sum;
    logic              trunc;
    logic              load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_mode;
  } dp_stat_t;

endpackage

### rtl/psfc_dp.sv
// Datapath: configuration registers, roll filter, shared multiplier, accumulator and clamp.
module psfc_dp
  import psfc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_word_t              in_word,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output out_word_t             out_word
);

  localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) <<< GAIN_FRAC_BITS) - ACC_W'(1);

  logic [8:0]         smooth_r;
  logic signed [23:0] angle_gain_r;
  logic signed [23:0] tilt_gain_r;
  logic signed [23:0] pos_gain_r;
  logic signed [23:0] speed_gain_r;
  logic signed [23:0] turn_gain_r;
  logic signed [15:0] turn_target_r;
  logic [22:0]        limit_r;

  logic signed [15:0] fr_r;
  logic signed [15:0] roll_off_r;
  logic signed [31:0] last_pos_r;
  logic signed [31:0] pos_off_r;
  logic               run_r;

  in_word_t           in_r;

  logic [8:0]          w_sat;
  logic signed [9:0]   w_s;
  logic signed [16:0]  diff_f;
  logic signed [26:0]  wprod;
  logic signed [27:0]  fnum;

  logic signed [16:0]  roll_d;
  logic signed [32:0]  pos_d;
  logic signed [16:0]  yaw_d;
  logic signed [23:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_nxt;

  logic signed [PROD_W-1:0] prod_r;
  logic [TERM_W-1:0]        prod_term_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  y_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rsum_r;
  logic signed [ACC_W-1:0]  lsum_r;
  logic signed [ACC_W-1:0]  rt_nxt;
  logic signed [ACC_W-1:0]  lt_nxt;
  logic signed [ACC_W-1:0]  rt_r;
  logic signed [ACC_W-1:0]  lt_r;
  logic signed [ACC_W-1:0]  lim_p;
  logic signed [ACC_W-1:0]  lim_n;
  logic signed [ACC_W-1:0]  rc;
  logic signed [ACC_W-1:0]  lc;

  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r      <= RST_SMOOTH;
      angle_gain_r  <= RST_ANGLE_GAIN;
      tilt_gain_r   <= RST_TILT_GAIN;
      pos_gain_r    <= RST_POS_GAIN;
      speed_gain_r  <= RST_SPEED_GAIN;
      turn_gain_r   <= RST_TURN_GAIN;
      turn_target_r <= RST_TURN_TARGET;
      limit_r       <= RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTH:      smooth_r      <= cfg_data[8:0];
        REG_ANGLE_GAIN:  angle_gain_r  <= cfg_data;
        REG_TILT_GAIN:   tilt_gain_r   <= cfg_data;
        REG_POS_GAIN:    pos_gain_r    <= cfg_data;
        REG_SPEED_GAIN:  speed_gain_r  <= cfg_data;
        REG_TURN_GAIN:   turn_gain_r   <= cfg_data;
        REG_TURN_TARGET: turn_target_r <= cfg_data[15:0];
        REG_DRIVE_LIMIT: limit_r       <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_sat  = (smooth_r > SMOOTH_MAX) ? SMOOTH_MAX : smooth_r;
    w_s    = $signed({1'b0, w_sat});
    diff_f = {fr_r[15], fr_r} - {in_r.roll_angle[15], in_r.roll_angle};
    wprod  = w_s * diff_f;
    fnum   = {{4{in_r.roll_angle[15]}}, in_r.roll_angle, 8'd0}
             + {wprod[26], wprod} + 28'sd128;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r       <= '0;
      roll_off_r <= '0;
      last_pos_r <= '0;
      pos_off_r  <= '0;
      run_r      <= 1'b0;
    end else if (cmd.toggle) begin
      run_r      <= ~run_r;
      roll_off_r <= fr_r;
      pos_off_r  <= last_pos_r;
    end else if (cmd.filt) begin
      fr_r       <= fnum[23:8];
      last_pos_r <= in_r.wheel_position;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_word;
    end
  end

  always_comb begin
    roll_d = {fr_r[15], fr_r} - {roll_off_r[15], roll_off_r};
    pos_d  = {in_r.wheel_position[31], in_r.wheel_position} - {pos_off_r[31], pos_off_r};
    yaw_d  = {turn_target_r[15], turn_target_r} - {in_r.yaw_rate[15], in_r.yaw_rate};
    case (cmd.term)
      TERM_ROLL: begin
        mul_a = angle_gain_r;
        mul_b = {{(OPB_W-17){roll_d[16]}}, roll_d};
      end
      TERM_TILT: begin
        mul_a = tilt_gain_r;
        mul_b = {{(OPB_W-16){in_r.tilt_rate[15]}}, in_r.tilt_rate};
      end
      TERM_POS: begin
        mul_a = pos_gain_r;
        mul_b = {{(OPB_W-33){pos_d[32]}}, pos_d};
      end
      TERM_SPEED: begin
        mul_a = speed_gain_r;
        mul_b = {{(OPB_W-32){in_r.wheel_speed[31]}}, in_r.wheel_speed};
      end
      TERM_TURN: begin
        mul_a = turn_gain_r;
        mul_b = {{(OPB_W-17){yaw_d[16]}}, yaw_d};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    prod_term_r <= cmd.term;
    if (cmd.filt) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      if (prod_term_r == TERM_TURN) begin
        y_r <= prod_ext;
      end else begin
        acc_r <= acc_r - prod_ext;
      end
    end
    if (cmd.sum) begin
      rsum_r <= acc_r + y_r;
      lsum_r <= acc_r - y_r;
    end
    if (cmd.trunc) begin
      rt_r <= rt_nxt;
      lt_r <= lt_nxt;
    end
  end

  always_comb begin
    rt_nxt = (rsum_r + (rsum_r[ACC_W-1] ? RND : ACC_W'(0))) >>> GAIN_FRAC_BITS;
    lt_nxt = (lsum_r + (lsum_r[ACC_W-1] ? RND : ACC_W'(0))) >>> GAIN_FRAC_BITS;
    lim_p  = $signed({{(ACC_W-23){1'b0}}, limit_r});
    lim_n  = -lim_p;
    if (rt_r > lim_p) begin
      rc = lim_p;
    end else if (rt_r < lim_n) begin
      rc = lim_n;
    end else begin
      rc = rt_r;
    end
    if (lt_r > lim_p) begin
      lc = lim_p;
    end else if (lt_r < lim_n) begin
      lc = lim_n;
    end else begin
      lc = lt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (run_r) begin
        out_r.right_drive <= rc[23:0];
        out_r.left_drive  <= -lc[23:0];
        out_r.running     <= 1'b1;
      end else begin
        out_r.right_drive <= '0;
        out_r.left_drive  <= '0;
        out_r.running     <= 1'b0;
      end
    end
  end

  assign stat.run_mode = run_r;
  assign out_word      = out_r;

endmodule

### rtl/psfc_ctrl.sv
// Controller: sequences filter, MAC and rounding (when running) and load per tick word.
module psfc_ctrl
  import psfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILT = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_TRNC = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [TERM_W-1:0] term_r;
  logic [TERM_W-1:0] term_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    cmd       = '0;
    cmd.term  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_TOGGLE) begin
            cmd.toggle = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt   = S_FILT;
          end
        end
      end
      S_FILT: begin
        cmd.filt  = 1'b1;
        term_nxt  = TERM_ROLL;
        state_nxt = stat.run_mode ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (term_r == TERM_TURN) begin
          state_nxt = S_ACC;
        end else begin
          term_nxt = term_r + TERM_W'(1);
        end
      end
      S_ACC: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TRNC;
      end
      S_TRNC: begin
        cmd.trunc = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= TERM_ROLL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/pendulum_state_feedback_controller.sv
// Top level of the pendulum balance controller: controller and datapath.
//
//   channel  signals                          direction
//   in       in_valid, in_stall, in_word      tick or toggle words in
//   out      out_valid, out_stall, out_word   drive words out
//   cfg      cfg_we, cfg_index, cfg_data      register writes
//
// While running, a tick word goes through the filter, five passes of the one
// 24x34 multiplier, sum, round and load before the next word is accepted; while
// stopped it goes from the filter straight to the load. A toggle word gives no word.
// Synchronous active-low reset restores register defaults and stops the loop.
// A full output register holds under out_stall; the sequencer waits to load it.
module pendulum_state_feedback_controller
  import psfc_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  psfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_word.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  psfc_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.running |-> out_word.right_drive == 24'sd0
                                       && out_word.left_drive == 24'sd0)
    else $error("stopped word carries nonzero drive");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.running |-> out_word.right_drive != 24'h800000
                                      && out_word.left_drive != 24'h800000)
    else $error("drive outside clamp range");

  a_toggle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.cmd == CMD_TOGGLE |=> !$rose(out_valid) && !in_stall)
    else $error("toggle word produced a result or busy cycle");

endmodule

### test/testbench.sv
// Testbench for the pendulum balance controller: predicts every drive word and checks it.
module testbench;
  import psfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 8;
  localparam int GAP_PCT      = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 200;
  localparam int TOGGLE_PCT   = 5;

  localparam longint POS_MIN  = -64'sd2147483648;
  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint GAIN_MIN = -64'sd8388608;
  localparam longint GAIN_MAX = 64'sd8388607;
  localparam longint LIM_MAX  = 64'sd8388607;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SMOOTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [8:0]         smooth_r      = RST_SMOOTH;
  logic signed [23:0] angle_gain_r  = RST_ANGLE_GAIN;
  logic signed [23:0] tilt_gain_r   = RST_TILT_GAIN;
  logic signed [23:0] pos_gain_r    = RST_POS_GAIN;
  logic signed [23:0] speed_gain_r  = RST_SPEED_GAIN;
  logic signed [23:0] turn_gain_r   = RST_TURN_GAIN;
  logic signed [15:0] turn_target_r = RST_TURN_TARGET;
  logic [22:0]        limit_r       = RST_DRIVE_LIMIT;

  logic signed [15:0] filt_roll = '0;
  logic signed [15:0] roll_off  = '0;
  logic signed [31:0] last_pos  = '0;
  logic signed [31:0] pos_off   = '0;
  logic               run_mode  = 1'b0;

  out_word_t drive_queue[$];
  int        mismatches = 0;
  bit        steady = 1'b0;
  logic      hold_pending = 1'b0;

  pendulum_state_feedback_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #12000000;
    $display("** pendulum_state_feedback_controller: FAILED **");
    $finish;
  end

  function automatic longint clamp_drive(input longint v);
    longint lim;
    lim = limit_r;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint drop_fraction(input longint s);
    if (s < 0) return -((-s) >>> GAIN_FRAC_BITS_DEF);
    return s >>> GAIN_FRAC_BITS_DEF;
  endfunction

  task automatic predict_drive(input in_word_t w);
    longint wt, roll, tilt, yaw, pos, spd, acc, u, yterm;
    out_word_t r;
    if (w.cmd == CMD_TOGGLE) begin
      run_mode = !run_mode;
      roll_off = filt_roll;
      pos_off = last_pos;
      return;
    end
    roll = $signed(w.roll_angle);
    tilt = $signed(w.tilt_rate);
    yaw = $signed(w.yaw_rate);
    pos = $signed(w.wheel_position);
    spd = $signed(w.wheel_speed);
    wt = (smooth_r > SMOOTH_MAX) ? 64'sd256 : longint'(smooth_r);
    acc = filt_roll;
    acc = wt * acc + (256 - wt) * roll + 128;
    filt_roll = 16'(acc >>> 8);
    last_pos = w.wheel_position;
    r = '0;
    if (run_mode) begin
      acc = filt_roll;
      u = -longint'(angle_gain_r) * (acc - longint'(roll_off))
          - longint'(tilt_gain_r) * tilt
          - longint'(pos_gain_r) * (pos - longint'(pos_off))
          - longint'(speed_gain_r) * spd;
      yterm = longint'(turn_gain_r) * (longint'(turn_target_r) - yaw);
      r.right_drive = 24'(clamp_drive(drop_fraction(u + yterm)));
      r.left_drive = 24'(-clamp_drive(drop_fraction(u - yterm)));
      r.running = 1'b1;
    end
    drive_queue.push_back(r);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_queue.size() == 0) begin
        $error("unexpected drive word: right_drive %0d left_drive %0d running %0b",
               out_word.right_drive, out_word.left_drive, out_word.running);
        mismatches++;
      end else begin
        exp_w = drive_queue.pop_front();
        if (out_word.right_drive !== exp_w.right_drive) begin
          $error("right_drive: expected %0d, actual %0d", exp_w.right_drive,
                 out_word.right_drive);
          mismatches++;
        end
        if (out_word.left_drive !== exp_w.left_drive) begin
          $error("left_drive: expected %0d, actual %0d", exp_w.left_drive,
                 out_word.left_drive);
          mismatches++;
        end
        if (out_word.running !== exp_w.running) begin
          $error("running: expected %0b, actual %0b", exp_w.running, out_word.running);
          mismatches++;
        end
      end
    end
  end

  initial begin : receiver
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_pending && left == 0) begin
        left = HOLD_CYCLES;
        hold_pending <= 1'b0;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic longint pick_value(input int bits, input int span);
    longint v;
    case ($urandom_range(0, 9))
      0: v = (longint'(1) << (bits - 1)) - 1;
      1: v = -(longint'(1) << (bits - 1));
      2, 3, 4, 5: v = longint'($urandom_range(0, 2 * span)) - span;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic in_word_t make_word(input logic cmd, input longint roll, tilt, yaw,
                                         input longint pos, spd);
    in_word_t w;
    w.cmd = cmd;
    w.roll_angle = 16'(roll);
    w.tilt_rate = 16'(tilt);
    w.yaw_rate = 16'(yaw);
    w.wheel_position = 32'(pos);
    w.wheel_speed = 32'(spd);
    return w;
  endfunction

  function automatic in_word_t make_tick();
    return make_word(CMD_TICK, pick_value(16, 300), pick_value(16, 300),
                     pick_value(16, 300), pick_value(32, 2000), pick_value(32, 500));
  endfunction

  function automatic in_word_t make_toggle();
    in_word_t w;
    w = make_tick();
    w.cmd = CMD_TOGGLE;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predict_drive(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic apply_config(input longint sm, ag, tg, pg, sg, tn, tgt, lim);
    smooth_r = 9'(sm);
    angle_gain_r = 24'(ag);
    tilt_gain_r = 24'(tg);
    pos_gain_r = 24'(pg);
    speed_gain_r = 24'(sg);
    turn_gain_r = 24'(tn);
    turn_target_r = 16'(tgt);
    limit_r = 23'(lim);
    write_reg(REG_SMOOTH, CFG_DATA_W'(smooth_r));
    write_reg(REG_ANGLE_GAIN, angle_gain_r);
    write_reg(REG_TILT_GAIN, tilt_gain_r);
    write_reg(REG_POS_GAIN, pos_gain_r);
    write_reg(REG_SPEED_GAIN, speed_gain_r);
    write_reg(REG_TURN_GAIN, turn_gain_r);
    write_reg(REG_TURN_TARGET, {{(CFG_DATA_W - 16){1'b0}}, turn_target_r});
    write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(limit_r));
    cfg_we <= 1'b0;
  endtask

  task automatic set_running(input logic on);
    if (run_mode != on) send_word(make_toggle());
  endtask

  task automatic test_reset_defaults();
    send_word(make_word(CMD_TICK, 32767, -32768, 32767, POS_MAX, POS_MIN));
    send_word(make_word(CMD_TICK, -32768, 32767, -32768, POS_MIN, POS_MAX));
    send_word(make_toggle());
    send_word(make_word(CMD_TICK, 200, -50, 30, 10, 5));
    send_word(make_word(CMD_TICK, 32767, 32767, -32768, 0, 0));
    send_word(make_toggle());
    send_word(make_word(CMD_TICK, -300, 40, 12, -7, 3));
  endtask

  task automatic test_extremes();
    wait_drained();
    apply_config(0, GAIN_MIN, GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, -32768, LIM_MAX);
    set_running(1'b0);
    send_word(make_word(CMD_TICK, 0, 0, 0, POS_MIN, 0));
    send_word(make_toggle());
    send_word(make_word(CMD_TICK, -32768, 32767, 32767, POS_MAX, POS_MIN));
    send_word(make_word(CMD_TICK, 32767, -32768, -32768, POS_MIN, POS_MAX));
    wait_drained();
    apply_config(SMOOTH_MAX, 700, -300, 5, -9, 250, 32767, 0);
    send_word(make_word(CMD_TICK, 32767, 100, -100, 50, 20));
    wait_drained();
    apply_config(511, 15000, 2400, 120, 40, 4800, 160, LIM_MAX);
    send_word(make_word(CMD_TICK, 1000, -20, 15, 900, -30));
    wait_drained();
    apply_config(257, -15000, 2400, -120, 40, -4800, -160, 120000);
    send_word(make_word(CMD_TICK, -1000, 20, -15, -900, 30));
    send_word(make_toggle());
    send_word(make_word(CMD_TICK, 500, 500, 500, 500, 500));
  endtask

  task automatic test_random_phases();
    longint sm, lim;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0: sm = 0;
        1: sm = SMOOTH_MAX;
        2: sm = $urandom_range(257, 511);
        default: sm = $urandom_range(0, 256);
      endcase
      case ($urandom_range(0, 4))
        0: lim = 0;
        1: lim = LIM_MAX;
        2: lim = $urandom_range(0, 1000);
        default: lim = $urandom_range(1000, 500000);
      endcase
      apply_config(sm, pick_value(24, 20000), pick_value(24, 20000), pick_value(24, 2000),
                   pick_value(24, 2000), pick_value(24, 20000), pick_value(16, 300), lim);
      steady = (p == 2);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < TOGGLE_PCT) send_word(make_toggle());
        else send_word(make_tick());
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    apply_config(RST_SMOOTH, 15000, 2400, 300, 50, 4800, 0, 120000);
    set_running(1'b1);
    hold_pending <= 1'b1;
    repeat (40) send_word(make_tick());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (mismatches == 0) begin
      $display("** pendulum_state_feedback_controller: PASSED **");
    end else begin
      $display("** pendulum_state_feedback_controller: FAILED **");
    end
    $finish;
  end

endmodule

### pendulum_state_feedback_controller.f
rtl/psfc_pkg.sv
rtl/psfc_dp.sv
rtl/psfc_ctrl.sv
rtl/pendulum_state_feedback_controller.sv
test/testbench.sv
